### hw/rtl/hqst_pkg.sv
// shared types, character codes and helpers for the query string tokenizer
package hqst_pkg;

	// character codes
	localparam logic [7:0] CH_NUL     = 8'h00;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_SLASH   = 8'h2f;
	localparam logic [7:0] CH_QUEST   = 8'h3f;
	localparam logic [7:0] CH_AMP     = 8'h26;
	localparam logic [7:0] CH_EQUAL   = 8'h3d;
	localparam logic [7:0] CH_PLUS    = 8'h2b;
	localparam logic [7:0] CH_PERCENT = 8'h25;

	// token kinds
	localparam logic [1:0] KIND_PATH  = 2'd0;
	localparam logic [1:0] KIND_NAME  = 2'd1;
	localparam logic [1:0] KIND_VALUE = 2'd2;

	// escape sequence progress
	localparam logic [1:0] ESC_NONE = 2'd0;
	localparam logic [1:0] ESC_HIGH = 2'd1;
	localparam logic [1:0] ESC_LOW  = 2'd2;

	// result queue between front and back
	localparam int QDEPTH = 4;
	localparam int QPW    = $clog2(QDEPTH);
	localparam int QCW    = $clog2(QDEPTH + 1);

	typedef enum logic [6:0] {
		PH_IDLE  = 7'b0000001,
		PH_SKIP  = 7'b0000010,
		PH_PATH  = 7'b0000100,
		PH_NAME  = 7'b0001000,
		PH_VALUE = 7'b0010000,
		PH_DONE  = 7'b0100000,
		PH_DROP  = 7'b1000000
	} phase_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       char_valid;
		logic [1:0] kind;
		logic [3:0] arg_index;
		logic       token_end;
		logic       request_end;
		logic       empty_path;
		logic       no_value;
		logic       args_dropped;
	} res_t;

	// non-hex digits count as zero
	function automatic logic [3:0] hex_value(input logic [7:0] c);
		logic [3:0] v;
		v = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) v = 4'(c - 8'h30);
		else if (c >= 8'h61 && c <= 8'h66) v = 4'(c - 8'h57);
		else if (c >= 8'h41 && c <= 8'h46) v = 4'(c - 8'h37);
		return v;
	endfunction

endpackage

### hw/rtl/hqst_front.sv
// front part: per-byte tokenizer state machine, one item per cycle while in_fire is high
module hqst_front #(
	parameter int MAX_LINE = 256,
	parameter int MAX_ARGS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_fire,
	input  logic [7:0]        ch,
	input  logic              line_start,
	output logic              res_valid,
	output hqst_pkg::res_t    res
);

	localparam int PW  = $clog2(MAX_LINE + 1);
	localparam int ACW = (MAX_ARGS > 1) ? $clog2(MAX_ARGS) : 1;
	localparam int IW  = (ACW > 4) ? ACW : 4;
	localparam logic [PW-1:0]  POS_LIMIT = PW'(MAX_LINE);
	localparam logic [ACW-1:0] LAST_ARG  = ACW'(MAX_ARGS - 1);

	hqst_pkg::phase_t ph_q, ph_c, ph_n;
	logic [1:0]     esc_q, esc_c, esc_n;
	logic [3:0]     hn_q, hn_c, hn_n;
	logic [ACW-1:0] ac_q, ac_c, ac_n;
	logic [PW-1:0]  pos_q, pos_c, pos_n;
	logic           thb_q, thb_c, thb_n;
	logic           drop_q, drop_c, drop_n;

	logic           limit;
	logic           endreq;
	logic [IW-1:0]  idx_w;
	logic [1:0]     kind_c;
	logic [7:0]     dec_char;

	always_comb begin
		ph_c   = ph_q;
		esc_c  = esc_q;
		hn_c   = hn_q;
		ac_c   = ac_q;
		pos_c  = pos_q;
		thb_c  = thb_q;
		drop_c = drop_q;
		// a new line abandons whatever was in progress
		if (line_start) begin
			ph_c   = hqst_pkg::PH_SKIP;
			esc_c  = hqst_pkg::ESC_NONE;
			hn_c   = 4'd0;
			ac_c   = '0;
			pos_c  = '0;
			thb_c  = 1'b0;
			drop_c = 1'b0;
		end

		limit    = (pos_c == POS_LIMIT);
		endreq   = limit || ch == hqst_pkg::CH_SPACE || ch == hqst_pkg::CH_NUL;
		idx_w    = IW'(ac_c);
		kind_c   = (ph_c == hqst_pkg::PH_NAME) ? hqst_pkg::KIND_NAME : hqst_pkg::KIND_VALUE;
		dec_char = (ch == hqst_pkg::CH_PLUS) ? hqst_pkg::CH_SPACE : ch;

		ph_n   = ph_c;
		esc_n  = esc_c;
		hn_n   = hn_c;
		ac_n   = ac_c;
		pos_n  = pos_c;
		thb_n  = thb_c;
		drop_n = drop_c;
		res_valid = 1'b0;
		res = '0;

		unique case (ph_c)
			hqst_pkg::PH_IDLE, hqst_pkg::PH_DONE: begin
			end
			hqst_pkg::PH_SKIP: begin
				if (!limit) pos_n = pos_c + PW'(1);
				if (limit || ch == hqst_pkg::CH_NUL) begin
					ph_n = hqst_pkg::PH_DONE;
					res_valid = 1'b1;
					res.token_end = 1'b1;
					res.request_end = 1'b1;
					res.empty_path = 1'b1;
				end else if (ch == hqst_pkg::CH_SLASH) begin
					ph_n = hqst_pkg::PH_PATH;
				end
			end
			hqst_pkg::PH_PATH: begin
				if (!limit) pos_n = pos_c + PW'(1);
				res_valid = 1'b1;
				if (endreq || ch == hqst_pkg::CH_QUEST) begin
					if (endreq) begin
						ph_n = hqst_pkg::PH_DONE;
					end else begin
						ph_n  = hqst_pkg::PH_NAME;
						ac_n  = '0;
						esc_n = hqst_pkg::ESC_NONE;
					end
					res.token_end = 1'b1;
					res.request_end = endreq;
					res.empty_path = !thb_c;
				end else begin
					thb_n = 1'b1;
					res.out_char = ch;
					res.char_valid = 1'b1;
				end
			end
			hqst_pkg::PH_DROP: begin
				if (!limit) pos_n = pos_c + PW'(1);
				if (endreq) begin
					ph_n = hqst_pkg::PH_DONE;
					res_valid = 1'b1;
					res.request_end = 1'b1;
				end
			end
			hqst_pkg::PH_NAME, hqst_pkg::PH_VALUE: begin
				if (!limit) pos_n = pos_c + PW'(1);
				res.kind = kind_c;
				res.arg_index = idx_w[3:0];
				if (endreq || ch == hqst_pkg::CH_AMP ||
				    (ph_c == hqst_pkg::PH_NAME && ch == hqst_pkg::CH_EQUAL)) begin
					// any unfinished escape is dropped here
					esc_n = hqst_pkg::ESC_NONE;
					if (endreq) begin
						ph_n = hqst_pkg::PH_DONE;
					end else if (ch == hqst_pkg::CH_EQUAL) begin
						ph_n = hqst_pkg::PH_VALUE;
					end else if (ac_c == LAST_ARG) begin
						drop_n = 1'b1;
						ph_n = hqst_pkg::PH_DROP;
					end else begin
						ac_n = ac_c + ACW'(1);
						ph_n = hqst_pkg::PH_NAME;
					end
					res_valid = 1'b1;
					res.token_end = 1'b1;
					res.request_end = endreq;
					res.no_value = (ph_c == hqst_pkg::PH_NAME) && (ch != hqst_pkg::CH_EQUAL);
				end else if (esc_c == hqst_pkg::ESC_HIGH) begin
					hn_n  = hqst_pkg::hex_value(ch);
					esc_n = hqst_pkg::ESC_LOW;
				end else if (esc_c == hqst_pkg::ESC_LOW) begin
					esc_n = hqst_pkg::ESC_NONE;
					res_valid = 1'b1;
					res.out_char = {hn_c, hqst_pkg::hex_value(ch)};
					res.char_valid = 1'b1;
				end else if (ch == hqst_pkg::CH_PERCENT) begin
					esc_n = hqst_pkg::ESC_HIGH;
				end else begin
					res_valid = 1'b1;
					res.out_char = dec_char;
					res.char_valid = 1'b1;
				end
			end
			default: begin
				ph_n = hqst_pkg::PH_IDLE;
			end
		endcase
		res.args_dropped = drop_n;
		if (!in_fire) res_valid = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= hqst_pkg::PH_IDLE;
			esc_q  <= hqst_pkg::ESC_NONE;
			hn_q   <= 4'd0;
			ac_q   <= '0;
			pos_q  <= '0;
			thb_q  <= 1'b0;
			drop_q <= 1'b0;
		end else if (in_fire) begin
			ph_q   <= ph_n;
			esc_q  <= esc_n;
			hn_q   <= hn_n;
			ac_q   <= ac_n;
			pos_q  <= pos_n;
			thb_q  <= thb_n;
			drop_q <= drop_n;
		end
	end

	a_empty_path_ends_path: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.empty_path |-> res.token_end && res.kind == hqst_pkg::KIND_PATH)
		else $error("empty path flag on a result that does not end the path");

	a_char_not_marker: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.char_valid |-> !res.token_end && !res.request_end)
		else $error("byte result also marked as a token end");

	a_drop_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && !line_start && drop_q |=> drop_q)
		else $error("dropped flag cleared within a line");

endmodule

### hw/rtl/hqst_queue.sv
// short result queue between the tokenizer and the output stage
module hqst_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  hqst_pkg::res_t    push_data,
	output logic              full,
	input  logic              pop,
	output hqst_pkg::res_t    pop_data,
	output logic              empty
);

	hqst_pkg::res_t                  entry_q [hqst_pkg::QDEPTH];
	logic [hqst_pkg::QPW-1:0]        wr_ptr_q;
	logic [hqst_pkg::QPW-1:0]        rd_ptr_q;
	logic [hqst_pkg::QCW-1:0]        count_q;

	assign full     = (count_q == hqst_pkg::QCW'(hqst_pkg::QDEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + hqst_pkg::QPW'(1);
			if (pop) rd_ptr_q <= rd_ptr_q + hqst_pkg::QPW'(1);
			if (push && !pop) count_q <= count_q + hqst_pkg::QCW'(1);
			else if (pop && !push) count_q <= count_q - hqst_pkg::QCW'(1);
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= hqst_pkg::QCW'(hqst_pkg::QDEPTH))
		else $error("queue count beyond its depth");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("pop from an empty queue");

endmodule

### hw/rtl/hqst_back.sv
// back part: output register that drains the queue onto the master side
module hqst_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_empty,
	input  hqst_pkg::res_t    q_data,
	output logic              q_pop,
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [15:0]       m_axis_tdata,
	output logic [6:0]        m_axis_tuser,
	output logic              m_axis_tlast
);

	logic           out_valid_q;
	hqst_pkg::res_t out_q;

	assign q_pop = !q_empty && (!out_valid_q || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (q_pop) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) out_q <= q_data;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'd0, out_q.arg_index, out_q.out_char};
	assign m_axis_tuser  = {out_q.args_dropped, out_q.no_value, out_q.empty_path,
	                        out_q.token_end, out_q.kind, out_q.char_valid};
	assign m_axis_tlast  = out_q.request_end;

	a_fill_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		!q_empty && !out_valid_q |=> out_valid_q)
		else $error("output register left empty while the queue holds an item");

endmodule

### hw/rtl/http_query_string_tokenizer.sv
// top level of the request line tokenizer with query string decoding
//
//  channel   dir  tdata                          tuser / tlast
//  s_axis    in   [7:0] ch                       tuser[0] line_start
//  m_axis    out  [7:0] out_char, [11:8] arg_idx tuser: char_valid, kind, token_end,
//                                                empty_path, no_value, args_dropped;
//                                                tlast request_end
//
// one input item per cycle while the queue is not full; a result passes the queue and then the output register
// the state machine holds the whole per-line state, so its update sets the rate
// a four-entry queue and an output register decouple input from output stalls
// s_axis_tready drops only while the queue is full
// asynchronous reset returns to idle; bytes before a line_start are ignored
module http_query_string_tokenizer #(
	parameter int MAX_LINE = 256,
	parameter int MAX_ARGS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] ch
	input  logic [0:0]  s_axis_tuser,   // [0] line_start
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [7:0] out_char, [11:8] arg_index, rest zero
	output logic [6:0]  m_axis_tuser,   // [0] char_valid, [2:1] kind, [3] token_end,
	                                    // [4] empty_path, [5] no_value, [6] args_dropped
	output logic        m_axis_tlast    // request_end
);

	logic           q_full;
	logic           q_empty;
	logic           q_pop;
	logic           in_fire;
	logic           res_valid;
	hqst_pkg::res_t res;
	hqst_pkg::res_t q_data;

	assign s_axis_tready = !q_full;
	assign in_fire       = s_axis_tvalid && s_axis_tready;

	hqst_front #(
		.MAX_LINE (MAX_LINE),
		.MAX_ARGS (MAX_ARGS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_fire    (in_fire),
		.ch         (s_axis_tdata),
		.line_start (s_axis_tuser[0]),
		.res_valid  (res_valid),
		.res        (res)
	);

	hqst_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_data),
		.empty     (q_empty)
	);

	hqst_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_empty       (q_empty),
		.q_data        (q_data),
		.q_pop         (q_pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

### tb/tb_http_query_string_tokenizer.sv
// self-checking testbench for the request line tokenizer with query string decoding
module tb_http_query_string_tokenizer;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_LINE    = 256;
	localparam int MAX_ARGS    = 16;
	localparam int BYTE_TARGET = 1250;
	localparam int CYCLE_LIMIT = 300000;
	localparam int DRAIN_WAIT  = 16;

	typedef struct {
		logic [7:0] ch;
		logic       line_start;
		bit         hold;
	} req_byte_t;

	typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_mode_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'd0;   // [7:0] ch
	logic [0:0]  s_axis_tuser = 1'b0;   // [0] line_start
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;          // [7:0] out_char, [11:8] arg_index
	logic [6:0]  m_axis_tuser;          // [0] char_valid, [2:1] kind, [3] token_end,
	                                    // [4] empty_path, [5] no_value, [6] args_dropped
	logic        m_axis_tlast;          // request_end

	req_byte_t      byte_queue[$];
	hqst_pkg::res_t expected_tokens[$];
	logic [7:0]     line_buf[$];
	int             queued_total = 0;
	int             mismatch_count = 0;
	int             cycle_count = 0;
	int             burst_left = 0;
	int             gap_left = 0;
	int             rx_left = 0;
	rx_mode_t       rx_mode = RX_OPEN;
	string alnum_set = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789-_.";
	string hex_set = "0123456789abcdefABCDEF";

	// tokenizer state as the predictor sees it
	hqst_pkg::phase_t tk_phase = hqst_pkg::PH_IDLE;
	logic [1:0]       tk_esc = hqst_pkg::ESC_NONE;
	logic [3:0]       tk_high = 4'd0;
	int               tk_args = 0;
	int               tk_pos = 0;
	bit               tk_has_bytes = 1'b0;
	bit               tk_dropped = 1'b0;

	http_query_string_tokenizer #(
		.MAX_LINE(MAX_LINE),
		.MAX_ARGS(MAX_ARGS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	always #6 clk = ~clk;

	always @(posedge clk) cycle_count <= cycle_count + 1;

	function automatic logic [3:0] hex_nibble(input logic [7:0] c);
		if (c >= "0" && c <= "9") return c[3:0];
		if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) return c[3:0] + 4'd9;
		return 4'd0;
	endfunction

	task automatic emit(input hqst_pkg::res_t r);
		r.args_dropped = tk_dropped;
		expected_tokens.push_back(r);
	endtask

	// works out the result, if any, of one accepted byte
	task automatic tokenize_byte(input logic [7:0] c, input logic ls);
		logic at_limit;
		logic ends;
		hqst_pkg::res_t r;
		r = '0;
		if (ls) begin
			tk_phase = hqst_pkg::PH_SKIP;
			tk_esc = hqst_pkg::ESC_NONE;
			tk_high = 4'd0;
			tk_args = 0;
			tk_pos = 0;
			tk_has_bytes = 1'b0;
			tk_dropped = 1'b0;
		end
		if (tk_phase == hqst_pkg::PH_IDLE || tk_phase == hqst_pkg::PH_DONE) return;
		at_limit = (tk_pos >= MAX_LINE);
		if (!at_limit) tk_pos++;
		ends = at_limit || c == hqst_pkg::CH_SPACE || c == hqst_pkg::CH_NUL;
		case (tk_phase)
			hqst_pkg::PH_SKIP: begin
				if (at_limit || c == hqst_pkg::CH_NUL) begin
					tk_phase = hqst_pkg::PH_DONE;
					r.token_end = 1'b1;
					r.request_end = 1'b1;
					r.empty_path = 1'b1;
					emit(r);
				end else if (c == hqst_pkg::CH_SLASH) begin
					tk_phase = hqst_pkg::PH_PATH;
				end
			end
			hqst_pkg::PH_PATH: begin
				if (ends || c == hqst_pkg::CH_QUEST) begin
					r.token_end = 1'b1;
					r.request_end = ends;
					r.empty_path = !tk_has_bytes;
					if (ends) begin
						tk_phase = hqst_pkg::PH_DONE;
					end else begin
						tk_phase = hqst_pkg::PH_NAME;
						tk_args = 0;
						tk_esc = hqst_pkg::ESC_NONE;
					end
					emit(r);
				end else begin
					// the path passes through undecoded
					tk_has_bytes = 1'b1;
					r.out_char = c;
					r.char_valid = 1'b1;
					emit(r);
				end
			end
			hqst_pkg::PH_DROP: begin
				if (ends) begin
					tk_phase = hqst_pkg::PH_DONE;
					r.request_end = 1'b1;
					emit(r);
				end
			end
			default: begin
				r.kind = (tk_phase == hqst_pkg::PH_NAME) ? hqst_pkg::KIND_NAME
					: hqst_pkg::KIND_VALUE;
				r.arg_index = tk_args[3:0];
				if (ends || c == hqst_pkg::CH_AMP ||
						(tk_phase == hqst_pkg::PH_NAME && c == hqst_pkg::CH_EQUAL)) begin
					r.no_value = (tk_phase == hqst_pkg::PH_NAME && c != hqst_pkg::CH_EQUAL);
					r.token_end = 1'b1;
					r.request_end = ends;
					// a half-finished escape is simply lost here
					tk_esc = hqst_pkg::ESC_NONE;
					if (ends) begin
						tk_phase = hqst_pkg::PH_DONE;
					end else if (c == hqst_pkg::CH_EQUAL) begin
						tk_phase = hqst_pkg::PH_VALUE;
					end else if (tk_args + 1 >= MAX_ARGS) begin
						tk_dropped = 1'b1;
						tk_phase = hqst_pkg::PH_DROP;
					end else begin
						tk_args++;
						tk_phase = hqst_pkg::PH_NAME;
					end
					emit(r);
				end else if (tk_esc == hqst_pkg::ESC_HIGH) begin
					tk_high = hex_nibble(c);
					tk_esc = hqst_pkg::ESC_LOW;
				end else if (tk_esc == hqst_pkg::ESC_LOW) begin
					tk_esc = hqst_pkg::ESC_NONE;
					r.out_char = {tk_high, hex_nibble(c)};
					r.char_valid = 1'b1;
					emit(r);
				end else if (c == hqst_pkg::CH_PERCENT) begin
					tk_esc = hqst_pkg::ESC_HIGH;
				end else begin
					r.out_char = (c == hqst_pkg::CH_PLUS) ? hqst_pkg::CH_SPACE : c;
					r.char_valid = 1'b1;
					emit(r);
				end
			end
		endcase
	endtask

	task automatic note_mismatch(input string what, input hqst_pkg::res_t want,
			input hqst_pkg::res_t got);
		mismatch_count++;
		if (mismatch_count <= 10) begin
			$display("%0t %s: want char %02h cv %0d kind %0d idx %0d te %0d re %0d",
				$realtime, what, want.out_char, want.char_valid, want.kind, want.arg_index,
				want.token_end, want.request_end);
			$display("    want ep %0d nv %0d ad %0d",
				want.empty_path, want.no_value, want.args_dropped);
			$display("    got char %02h cv %0d kind %0d idx %0d te %0d re %0d",
				got.out_char, got.char_valid, got.kind, got.arg_index, got.token_end,
				got.request_end);
			$display("    got ep %0d nv %0d ad %0d pad %h",
				got.empty_path, got.no_value, got.args_dropped, m_axis_tdata[15:12]);
		end
	endtask

	// sender: bursts of random length with gaps, optional hold until drained
	always @(posedge clk) begin : drive
		logic      load;
		req_byte_t nxt;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= 8'd0;
			s_axis_tuser <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) tokenize_byte(s_axis_tdata, s_axis_tuser[0]);
			if (!s_axis_tvalid || s_axis_tready) begin
				load = 1'b0;
				if (gap_left > 0) begin
					gap_left--;
				end else if (byte_queue.size() > 0 &&
						!(byte_queue[0].hold && expected_tokens.size() > 0)) begin
					nxt = byte_queue.pop_front();
					load = 1'b1;
					s_axis_tdata <= nxt.ch;
					s_axis_tuser <= nxt.line_start;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 120)
							: $urandom_range(1, 12);
						gap_left = $urandom_range(1, 6);
					end
				end
				s_axis_tvalid <= load;
			end
		end
	end

	// receiver: stall pattern changes every so often
	always @(posedge clk) begin : stall
		logic rdy;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (rx_left == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 3));
				rx_left = $urandom_range(20, 150);
			end else begin
				rx_left--;
			end
			case (rx_mode)
				RX_OPEN:   rdy = 1'b1;
				RX_COIN:   rdy = $urandom_range(0, 1) != 0;
				RX_SPARSE: rdy = (cycle_count % 4) == 0;
				default:   rdy = $urandom_range(0, 6) != 0;
			endcase
			m_axis_tready <= rdy;
		end
	end

	always @(posedge clk) begin : watch
		hqst_pkg::res_t got;
		hqst_pkg::res_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.out_char = m_axis_tdata[7:0];
			got.arg_index = m_axis_tdata[11:8];
			got.char_valid = m_axis_tuser[0];
			got.kind = m_axis_tuser[2:1];
			got.token_end = m_axis_tuser[3];
			got.empty_path = m_axis_tuser[4];
			got.no_value = m_axis_tuser[5];
			got.args_dropped = m_axis_tuser[6];
			got.request_end = m_axis_tlast;
			if (expected_tokens.size() == 0) begin
				note_mismatch("result with nothing expected", '0, got);
			end else begin
				want = expected_tokens.pop_front();
				if (got !== want || m_axis_tdata[15:12] !== 4'd0)
					note_mismatch("wrong result", want, got);
			end
		end
	end

	task automatic put_text(input string s);
		for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
	endtask

	task automatic flush_line(input bit hold);
		req_byte_t b;
		for (int i = 0; i < line_buf.size(); i++) begin
			b.ch = line_buf[i];
			b.line_start = (i == 0);
			b.hold = hold && i == 0;
			byte_queue.push_back(b);
		end
		queued_total += line_buf.size();
		line_buf.delete();
	endtask

	// bytes without line_start, ignored unless a line is still open
	task automatic add_loose(input int n);
		req_byte_t b;
		for (int i = 0; i < n; i++) begin
			b.ch = 8'($urandom_range(0, 255));
			b.line_start = 1'b0;
			b.hold = 1'b0;
			byte_queue.push_back(b);
		end
		queued_total += n;
	endtask

	task automatic put_hex_digit();
		line_buf.push_back(hex_set[$urandom_range(0, hex_set.len() - 1)]);
	endtask

	task automatic put_token_char();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			line_buf.push_back(alnum_set[$urandom_range(0, alnum_set.len() - 1)]);
		end else if (r < 65) begin
			line_buf.push_back(hqst_pkg::CH_PLUS);
		end else if (r < 77) begin
			line_buf.push_back(hqst_pkg::CH_PERCENT);
			put_hex_digit();
			put_hex_digit();
		end else if (r < 81) begin
			// escape with digits that are not hex
			line_buf.push_back(hqst_pkg::CH_PERCENT);
			put_text(($urandom_range(0, 1) != 0) ? "zG" : "g%");
		end else if (r < 84) begin
			// may be cut off by whatever follows
			line_buf.push_back(hqst_pkg::CH_PERCENT);
			if ($urandom_range(0, 1) != 0) put_hex_digit();
		end else if (r < 88) begin
			line_buf.push_back(hqst_pkg::CH_EQUAL);
		end else if (r < 91) begin
			line_buf.push_back(hqst_pkg::CH_QUEST);
		end else begin
			line_buf.push_back(8'($urandom_range(0, 255)));
		end
	endtask

	task automatic gen_line(input int n);
		int         style;
		int         nargs;
		int         len;
		logic [7:0] c;
		style = $urandom_range(0, 99);
		if (style < 8 && n > 12) begin
			// garbage line
			len = $urandom_range(1, 20);
			for (int i = 0; i < len; i++) line_buf.push_back(8'($urandom_range(0, 255)));
			flush_line(1'b0);
			return;
		end
		case ($urandom_range(0, 2))
			0: put_text("GET ");
			1: ;
			default: begin
				len = $urandom_range(1, 3);
				for (int i = 0; i < len; i++) begin
					c = 8'($urandom_range(1, 255));
					if (c == hqst_pkg::CH_SLASH) c = "x";
					line_buf.push_back(c);
				end
			end
		endcase
		// line limit hit in the skip, path and value phases
		if (n == 3 || n == 6 || n == 9) begin
			if (n == 6) line_buf.push_back(hqst_pkg::CH_SLASH);
			if (n == 9) put_text("/p?a=");
			for (int i = 0; i < MAX_LINE + 4; i++) line_buf.push_back((n == 3) ? "A" : "v");
			flush_line(1'b0);
			return;
		end
		line_buf.push_back(hqst_pkg::CH_SLASH);
		len = $urandom_range(0, 8);
		for (int i = 0; i < len; i++) begin
			style = $urandom_range(0, 99);
			if (style < 70)
				line_buf.push_back(alnum_set[$urandom_range(0, alnum_set.len() - 1)]);
			else if (style < 80) line_buf.push_back(hqst_pkg::CH_PERCENT);
			else if (style < 88) line_buf.push_back(hqst_pkg::CH_PLUS);
			else if (style < 94)
				line_buf.push_back(($urandom_range(0, 1) != 0) ? hqst_pkg::CH_EQUAL
					: hqst_pkg::CH_AMP);
			else line_buf.push_back(8'($urandom_range(0, 255)));
		end
		if ($urandom_range(0, 9) < 8) begin
			line_buf.push_back(hqst_pkg::CH_QUEST);
			if (n == 4 || $urandom_range(0, 9) == 0) nargs = $urandom_range(14, 20);
			else nargs = $urandom_range(0, 5);
			for (int a = 0; a < nargs; a++) begin
				if (a > 0) line_buf.push_back(hqst_pkg::CH_AMP);
				len = (nargs > 8) ? $urandom_range(0, 2) : $urandom_range(0, 4);
				for (int i = 0; i < len; i++) put_token_char();
				if ($urandom_range(0, 4) != 0) begin
					line_buf.push_back(hqst_pkg::CH_EQUAL);
					len = (nargs > 8) ? $urandom_range(0, 2) : $urandom_range(0, 5);
					for (int i = 0; i < len; i++) put_token_char();
				end
			end
		end
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: begin
				line_buf.push_back(hqst_pkg::CH_SPACE);
				if ($urandom_range(0, 2) == 0) put_text("HTTP/1.1");
			end
			5, 6, 7: line_buf.push_back(hqst_pkg::CH_NUL);
			default: ;  // left open, the next line_start abandons it
		endcase
		flush_line(n == 1 || n == 11);
	endtask

	initial begin : stimulus
		int line_no;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// stray byte before any line
		add_loose(1);
		// path slash first, ends at once on NUL
		put_text("/");
		line_buf.push_back(hqst_pkg::CH_NUL);
		flush_line(1'b0);
		// top byte value, NUL before any path
		line_buf.push_back(8'hff);
		line_buf.push_back(hqst_pkg::CH_NUL);
		flush_line(1'b0);
		// path not decoded, extra '?' and '=', bad hex, empty arg, cut-off escape
		put_text("/%+?a?=%Fz=+&&b%4 ");
		flush_line(1'b0);
		// abandoned by the next line_start
		put_text("/ab");
		flush_line(1'b0);
		queued_total = 0;

		line_no = 0;
		while (queued_total < BYTE_TARGET) begin
			gen_line(line_no);
			if ($urandom_range(0, 99) < 8) add_loose($urandom_range(1, 4));
			line_no++;
		end

		while (byte_queue.size() != 0 || s_axis_tvalid) @(posedge clk);
		while (expected_tokens.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("tb_http_query_string_tokenizer OK");
		end else begin
			$display("tb_http_query_string_tokenizer NOT OK");
		end
		$finish;
	end

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) @(posedge clk);
		$display("timeout with %0d results outstanding", expected_tokens.size());
		$display("tb_http_query_string_tokenizer NOT OK");
		$finish;
	end

endmodule

### http_query_string_tokenizer.f
hw/rtl/hqst_pkg.sv
hw/rtl/hqst_front.sv
hw/rtl/hqst_queue.sv
hw/rtl/hqst_back.sv
hw/rtl/http_query_string_tokenizer.sv
tb/tb_http_query_string_tokenizer.sv
